[rtl/assert_macros.svh]
// Assertion macros for the checker file of this block.
// Depends on nothing; the checker that includes it must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge of clk, off while rst_n is low.
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is never true at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CHK(label, !(cond), msg)

`endif

[rtl/ipv4dq_pkg.sv]
// Package for the IPv4 dotted-quad validator: widths, character codes, status codes
// and the scan state type. Depends on nothing.
`default_nettype none

package ipv4dq_pkg;

  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 5;
  localparam int DIGIT_W  = 2;
  localparam int OCTET_W  = 10;
  localparam int DOT_W    = 3;

  // longest accepted string, in characters
  localparam logic [LEN_W-1:0] MAX_LEN = 5'd15;

  localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;

  localparam logic [OCTET_W-1:0] OCTET_MAX   = 10'd255;
  localparam logic [DIGIT_W-1:0] DIGITS_MAX  = 2'd3;
  localparam logic [DOT_W-1:0]   DOTS_NEEDED = 3'd3;
  localparam logic [LEN_W-1:0]   LEN_SAT     = 5'd31;
  localparam logic [DOT_W-1:0]   DOT_SAT     = 3'd7;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CHAR    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LONG_OCTET  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY_OCTET = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BIG_OCTET   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DOT_COUNT   = 3'd5;

  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [DIGIT_W-1:0]  digits;
    logic [OCTET_W-1:0]  octet;
    logic [DOT_W-1:0]    dots;
    logic [STATUS_W-1:0] err;
  } scan_state_t;

endpackage

`default_nettype wire

[rtl/ipv4dq_scan.sv]
// Per-character scan step of the dotted-quad validator: next scan state and
// the status for a terminator. Depends on ipv4dq_pkg.
`default_nettype none

module ipv4dq_scan (
  input  wire ipv4dq_pkg::scan_state_t           cur,
  input  wire logic [ipv4dq_pkg::CHAR_W-1:0]     char_code,
  output ipv4dq_pkg::scan_state_t                nxt,
  output logic [ipv4dq_pkg::STATUS_W-1:0]        status
);
  import ipv4dq_pkg::*;

  logic [3:0]         digit_val;
  logic [OCTET_W-1:0] octet_acc;
  logic [STATUS_W-1:0] close_err;

  // value*10 + digit as two shifts and adds, kept to the octet width
  assign digit_val = char_code[3:0] - CH_ZERO[3:0];
  assign octet_acc = (cur.octet << 3) + (cur.octet << 1)
                   + {{(OCTET_W-4){1'b0}}, digit_val};

  always_comb begin
    if (cur.digits == '0) begin
      close_err = ST_EMPTY_OCTET;
    end else if (cur.octet > OCTET_MAX) begin
      close_err = ST_BIG_OCTET;
    end else begin
      close_err = ST_OK;
    end
  end

  always_comb begin
    nxt    = cur;
    status = ST_OK;
    if (char_code == CH_NUL) begin
      // terminator: decide, then clear for the next string
      nxt = '0;
      if ((cur.len == '0) || (cur.len > MAX_LEN)) begin
        status = ST_BAD_CHAR;
      end else if (cur.err != ST_OK) begin
        status = cur.err;
      end else if (close_err != ST_OK) begin
        status = close_err;
      end else if (cur.dots != DOTS_NEEDED) begin
        status = ST_DOT_COUNT;
      end
    end else begin
      if (cur.len != LEN_SAT) begin
        nxt.len = cur.len + 1'b1;
      end
      if (cur.err == ST_OK) begin
        if (char_code inside {[CH_ZERO:CH_NINE]}) begin
          if (cur.digits == DIGITS_MAX) begin
            nxt.err = ST_LONG_OCTET;
          end else begin
            nxt.octet  = octet_acc;
            nxt.digits = cur.digits + 1'b1;
          end
        end else if (char_code == CH_DOT) begin
          if (close_err != ST_OK) begin
            nxt.err = close_err;
          end else begin
            nxt.digits = '0;
            nxt.octet  = '0;
            if (cur.dots != DOT_SAT) begin
              nxt.dots = cur.dots + 1'b1;
            end
          end
        end else begin
          nxt.err = ST_BAD_CHAR;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ipv4_dotted_quad_validator_top.sv]
// Top level of the IPv4 dotted-quad text validator: input register, scan step,
// result register. Depends on ipv4dq_pkg and ipv4dq_scan.
//
// Usage:
//   Input channel (in_*): one character per request, in_tdata[7:0] = char_code.
//   A zero byte ends the string. Non-zero characters produce no result.
//   Result channel (out_*): one request per terminator, out_tdata[2:0] = status
//   (0 ok, 1 bad length or character, 2 four-digit octet, 3 empty octet,
//   4 octet over 255, 5 dot count not three); out_tdata[7:3] are zero.
//   Path: a terminator passes the input register and then the result
//   register, which raises out_tvalid; it waits while a result is stalled.
//   Throughput: one character per cycle while no terminator waits, set by
//   the combinational scan step between the input and scan state registers.
//   Reset (rst_n low, synchronous): empties both stages and clears the scan
//   state, so the next character starts a fresh string.
//   Stall: while out_tready is low a held result stays put; ordinary characters
//   still advance, and only a second terminator waits in the input register,
//   which then drops in_tready until the result is taken.
`default_nettype none

module ipv4_dotted_quad_validator_top (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] char_code
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata   // [2:0] status, [7:3] zero
);
  import ipv4dq_pkg::*;

  // input register
  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;

  // scan state
  scan_state_t st_r;
  scan_state_t st_nxt;

  // result register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [STATUS_W-1:0] scan_status;

  logic s1_is_term;
  logic out_free;
  logic s1_adv;
  logic in_take;

  ipv4dq_scan u_scan (
    .cur       (st_r),
    .char_code (s1_char_r),
    .nxt       (st_nxt),
    .status    (scan_status)
  );

  // a terminator needs a free result slot; other characters always advance
  assign s1_is_term = (s1_char_r == CH_NUL);
  assign out_free   = !out_valid_r || out_tready;
  assign s1_adv     = s1_valid_r && (!s1_is_term || out_free);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign in_take    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // payload: load on every taken request
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_tdata[CHAR_W-1:0];
    end
  end

  // advance the scan state once per character leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_is_term;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && s1_is_term) begin
      out_status_r <= scan_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8-STATUS_W){1'b0}}, out_status_r};

endmodule

`default_nettype wire

[rtl/ipv4dq_checker.sv]
// Port-level checker for the dotted-quad validator, bound to the top level.
// Depends on assert_macros.svh and ipv4dq_pkg.
`default_nettype none
`include "assert_macros.svh"

module ipv4dq_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_tvalid,
  input wire       in_tready,
  input wire [7:0] in_tdata,
  input wire       out_tvalid,
  input wire       out_tready,
  input wire [7:0] out_tdata
);
  import ipv4dq_pkg::*;

  // hold a stalled result
  `ASSERT_CHK(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "stalled result changed or dropped")

  // a status is one of the defined codes, upper bits zero
  `ASSERT_NEVER(a_status_range, out_tvalid && ((out_tdata[2:0] > ST_DOT_COUNT) || (out_tdata[7:3] != 5'd0)), "status out of range")

  // a fresh result follows a terminator that passed the input register without waiting
  `ASSERT_CHK(a_rose_after_term, $rose(out_tvalid) |-> $past(in_tvalid && in_tready && (in_tdata == CH_NUL), 2), "result without terminator")

  // an idle pipe always takes the next request
  `ASSERT_CHK(a_ready_when_drained, (!out_tvalid && !$past(in_tvalid && in_tready)) |-> in_tready, "input stalled while drained")

endmodule

bind ipv4_dotted_quad_validator_top ipv4dq_checker u_ipv4dq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
